@@ rtl/pgdr_pkg.sv @@
`default_nettype none

package pgdr_pkg;

   // Default sizing of the node table and of the coordinates.
   localparam int MAX_NODES_DEFAULT  = 256;
   localparam int COORD_BITS_DEFAULT = 16;

   // Squared distance thresholds are 33 bits wide.
   localparam int DIST_BITS = 33;

   // Configuration register indexes.
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MIN_DIST = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MAX_DIST = 1'b1;

   // Command codes.
   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_RANK  = 2'd2;

   // One result item.
   typedef struct packed {
      logic       ok;
      logic [7:0] node_index;
      logic [7:0] node_degree;
      logic [8:0] node_total;
   } rsp_type;

   // Degree increment that saturates at the top of the 8-bit range.
   function automatic logic [7:0] degree_inc(input logic [7:0] deg);
      degree_inc = (deg == 8'hFF) ? deg : deg + 8'd1;
   endfunction

endpackage

`default_nettype wire

@@ rtl/pgdr_dist.sv @@
`default_nettype none

module pgdr_dist
   import pgdr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int TAG_BITS   = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [TAG_BITS-1:0]   in_tag,
   input  wire logic [COORD_BITS-1:0] new_x,
   input  wire logic [COORD_BITS-1:0] new_y,
   input  wire logic [COORD_BITS-1:0] old_x,
   input  wire logic [COORD_BITS-1:0] old_y,
   input  wire logic [DIST_BITS-1:0]  min_dist,
   input  wire logic [DIST_BITS-1:0]  max_dist,
   output logic                       out_valid,
   output logic [TAG_BITS-1:0]        out_tag,
   output logic                       out_hit,
   output logic                       busy
);

   localparam int SQ_BITS  = 2 * COORD_BITS;
   localparam int SUM_BITS = SQ_BITS + 1;
   localparam int CMP_BITS = (SUM_BITS > DIST_BITS) ? SUM_BITS : DIST_BITS;

   logic                  v1_ff, v2_ff, v3_ff;
   logic [TAG_BITS-1:0]   tag1_ff, tag2_ff, tag3_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff;
   logic [SQ_BITS-1:0]    sqx_ff, sqy_ff;
   logic                  hit_ff;
   logic [COORD_BITS-1:0] dx_in, dy_in;
   logic [SQ_BITS-1:0]    sqx_in, sqy_in;
   logic [SUM_BITS-1:0]   sum;
   logic [CMP_BITS-1:0]   sum_w;
   logic                  hit_in;

   // Absolute coordinate differences.
   assign dx_in = (new_x > old_x) ? new_x - old_x : old_x - new_x;
   assign dy_in = (new_y > old_y) ? new_y - old_y : old_y - new_y;

   // Squares of the registered differences.
   assign sqx_in = {{COORD_BITS{1'b0}}, dx_ff} * {{COORD_BITS{1'b0}}, dx_ff};
   assign sqy_in = {{COORD_BITS{1'b0}}, dy_ff} * {{COORD_BITS{1'b0}}, dy_ff};

   // Sum of squares against the open distance window.
   assign sum    = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign sum_w  = CMP_BITS'(sum);
   assign hit_in = (sum_w > CMP_BITS'(min_dist)) && (sum_w < CMP_BITS'(max_dist));

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      tag1_ff <= in_tag;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      tag2_ff <= tag1_ff;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      tag3_ff <= tag2_ff;
      hit_ff  <= hit_in;
   end

   assign out_valid = v3_ff;
   assign out_tag   = tag3_ff;
   assign out_hit   = hit_ff;
   assign busy      = v1_ff | v2_ff | v3_ff;

endmodule

`default_nettype wire

@@ rtl/proximity_graph_degree_ranker_top.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// request   in         start, busy            req_command, req_pos_x, req_pos_y, req_rank
// result    out        rsp_valid (strobe)     rsp_ok, rsp_node_index, rsp_node_degree,
//                                             rsp_node_total
// csr       in         csr_write_enable       csr_index, csr_write_data
//
// Clear, an unused command, a rejected add or a rejected rank read answer on the
// clock edge that takes the item. An add to a table of n nodes reads the nodes one
// per cycle through a registered memory read and a three-stage distance pipe, which
// drains before the node is stored; with an empty table no node is read.
// In a rank read, eight passes over the degree memory pick the degree bit by bit, and
// one more pass picks the node. Synchronous reset empties the table and sets the
// distance window to its defaults; no clearing pass is needed. Results are shown for
// one cycle and cannot be stalled.

module proximity_graph_degree_ranker_top
   import pgdr_pkg::*;
#(
   parameter int MAX_NODES  = MAX_NODES_DEFAULT,
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [1:0]              req_command,
   input  wire logic [15:0]             req_pos_x,
   input  wire logic [15:0]             req_pos_y,
   input  wire logic [7:0]              req_rank,
   output logic                         rsp_valid,
   output logic                         rsp_ok,
   output logic [7:0]                   rsp_node_index,
   output logic [7:0]                   rsp_node_degree,
   output logic [8:0]                   rsp_node_total,
   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [DIST_BITS-1:0]    csr_write_data
);

   localparam int AW       = $clog2(MAX_NODES);
   localparam int CW       = $clog2(MAX_NODES + 1);
   localparam int RW       = (CW > 8) ? CW : 8;
   localparam int TAG_BITS = AW + 8;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ADD_SCAN,
      S_ADD_DRAIN,
      S_ADD_FIN,
      S_RD_SCAN,
      S_RD_EVAL
   } state_type;

   // Control and response registers.
   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [DIST_BITS-1:0]  min_dist_ff, max_dist_ff;
   rsp_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]         k_ff, k_in;
   logic                  s1_valid_ff, s1_valid_in;
   logic [AW-1:0]         s1_k_ff;
   logic [COORD_BITS-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [7:0]            new_deg_ff, new_deg_in;
   logic [7:0]            want_ff, want_in;
   logic [7:0]            d_ff, d_in;
   logic [2:0]            bit_ff, bit_in;
   logic                  final_ff, final_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         ge_ff, ge_in;
   logic [RW-1:0]         match_ff, match_in;
   logic                  issue;

   // Memories and their registered read data.
   logic [2*COORD_BITS-1:0] coord_mem_ff [MAX_NODES];
   logic [7:0]              degree_mem_ff [MAX_NODES];
   logic [2*COORD_BITS-1:0] coord_rd_ff;
   logic [7:0]              degree_rd_ff;
   logic                    deg_we;
   logic [AW-1:0]           deg_wa;
   logic [7:0]              deg_wd;

   // Distance pipe connections.
   logic                dist_in_valid;
   logic                dist_out_valid;
   logic [TAG_BITS-1:0] dist_out_tag;
   logic                dist_hit;
   logic                dist_busy;
   logic [AW-1:0]       out_k;
   logic [7:0]          out_deg;

   // Scan helpers.
   logic          last_issue;
   logic          full;
   logic [7:0]    trial;
   logic          ge_hit;
   logic [CW-1:0] cnt_next;
   logic          eq_hit;
   logic [RW-1:0] skip;
   logic          found;

   assign last_issue = (CW'(k_ff) == count_ff - CW'(1));
   assign full       = (count_ff == CW'(MAX_NODES));
   assign trial      = d_ff | (8'd1 << bit_ff);
   assign ge_hit     = s1_valid_ff && (degree_rd_ff >= trial);
   assign cnt_next   = cnt_ff + CW'(ge_hit);
   assign eq_hit     = s1_valid_ff && (degree_rd_ff == d_ff);
   assign skip       = RW'(ge_ff) - RW'(1) - RW'(want_ff);
   assign found      = final_ff && eq_hit && (match_ff == skip);

   assign out_k   = dist_out_tag[TAG_BITS-1:8];
   assign out_deg = dist_out_tag[7:0];

   // Distance pipe is fed only by reads issued for an add.
   assign dist_in_valid = s1_valid_ff &&
                          (state_ff == S_ADD_SCAN || state_ff == S_ADD_DRAIN);

   pgdr_dist #(
      .COORD_BITS (COORD_BITS),
      .TAG_BITS   (TAG_BITS)
   ) u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dist_in_valid),
      .in_tag    ({s1_k_ff, degree_rd_ff}),
      .new_x     (nx_ff),
      .new_y     (ny_ff),
      .old_x     (coord_rd_ff[2*COORD_BITS-1:COORD_BITS]),
      .old_y     (coord_rd_ff[COORD_BITS-1:0]),
      .min_dist  (min_dist_ff),
      .max_dist  (max_dist_ff),
      .out_valid (dist_out_valid),
      .out_tag   (dist_out_tag),
      .out_hit   (dist_hit),
      .busy      (dist_busy)
   );

   // Degree write port: neighbor bumps during an add, the new node at its end.
   always_comb begin
      deg_we = (dist_out_valid && dist_hit) || (state_ff == S_ADD_FIN);
      if (state_ff == S_ADD_FIN) begin
         deg_wa = AW'(count_ff);
         deg_wd = new_deg_ff;
      end else begin
         deg_wa = out_k;
         deg_wd = degree_inc(out_deg);
      end
   end

   // Memory ports.
   always_ff @(posedge clock) begin
      if (state_ff == S_ADD_FIN) begin
         coord_mem_ff[AW'(count_ff)] <= {nx_ff, ny_ff};
      end
      if (deg_we) begin
         degree_mem_ff[deg_wa] <= deg_wd;
      end
      coord_rd_ff  <= coord_mem_ff[k_ff];
      degree_rd_ff <= degree_mem_ff[k_ff];
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= '0;
         max_dist_ff <= DIST_BITS'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MIN_DIST: min_dist_ff <= csr_write_data;
            CSR_MAX_DIST: max_dist_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      k_in         = k_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      new_deg_in   = new_deg_ff;
      want_in      = want_ff;
      d_in         = d_ff;
      bit_in       = bit_ff;
      final_in     = final_ff;
      cnt_in       = cnt_ff;
      ge_in        = ge_ff;
      match_in     = match_ff;
      issue        = 1'b0;

      // The new node gains a degree for every neighbor found.
      if (dist_out_valid && dist_hit) begin
         new_deg_in = degree_inc(new_deg_ff);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in = '{ok: 1'b0, node_index: 8'd0, node_degree: 8'd0,
                          node_total: 9'(count_ff)};
               unique case (req_command)
                  CMD_CLEAR: begin
                     count_in          = '0;
                     rsp_in.ok         = 1'b1;
                     rsp_in.node_total = 9'd0;
                     rsp_valid_in      = 1'b1;
                  end
                  CMD_ADD: begin
                     if (full) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        nx_in      = COORD_BITS'(req_pos_x);
                        ny_in      = COORD_BITS'(req_pos_y);
                        new_deg_in = 8'd0;
                        k_in       = '0;
                        state_in   = (count_ff == '0) ? S_ADD_FIN : S_ADD_SCAN;
                     end
                  end
                  CMD_RANK: begin
                     if (RW'(req_rank) >= RW'(count_ff)) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        want_in  = req_rank;
                        d_in     = 8'd0;
                        bit_in   = 3'd7;
                        final_in = 1'b0;
                        cnt_in   = '0;
                        ge_in    = count_ff;
                        match_in = '0;
                        k_in     = '0;
                        state_in = S_RD_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_ADD_SCAN: begin
            issue = 1'b1;
            k_in  = k_ff + AW'(1);
            if (last_issue) begin
               state_in = S_ADD_DRAIN;
            end
         end
         S_ADD_DRAIN: begin
            if (!s1_valid_ff && !dist_busy) begin
               state_in = S_ADD_FIN;
            end
         end
         S_ADD_FIN: begin
            count_in     = count_ff + CW'(1);
            rsp_in       = '{ok: 1'b1, node_index: 8'd0, node_degree: 8'd0,
                             node_total: 9'(count_ff + CW'(1))};
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_RD_SCAN: begin
            issue = 1'b1;
            k_in  = k_ff + AW'(1);
            if (last_issue) begin
               state_in = S_RD_EVAL;
            end
            if (!final_ff) begin
               cnt_in = cnt_next;
            end else if (found) begin
               rsp_in       = '{ok: 1'b1, node_index: 8'(s1_k_ff), node_degree: d_ff,
                                node_total: 9'(count_ff)};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (eq_hit) begin
               match_in = match_ff + RW'(1);
            end
         end
         S_RD_EVAL: begin
            if (!final_ff) begin
               // Keep the trial bit when enough nodes reach that degree.
               if (RW'(cnt_next) > RW'(want_ff)) begin
                  d_in  = trial;
                  ge_in = cnt_next;
               end
               cnt_in   = '0;
               match_in = '0;
               k_in     = '0;
               state_in = S_RD_SCAN;
               if (bit_ff == 3'd0) begin
                  final_in = 1'b1;
               end else begin
                  bit_in = bit_ff - 3'd1;
               end
            end else begin
               rsp_in       = '{ok: found, node_index: found ? 8'(s1_k_ff) : 8'd0,
                                node_degree: found ? d_ff : 8'd0,
                                node_total: 9'(count_ff)};
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= s1_valid_in;
      end
      rsp_ff     <= rsp_in;
      s1_k_ff    <= k_ff;
      k_ff       <= k_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      new_deg_ff <= new_deg_in;
      want_ff    <= want_in;
      d_ff       <= d_in;
      bit_ff     <= bit_in;
      final_ff   <= final_in;
      cnt_ff     <= cnt_in;
      ge_ff      <= ge_in;
      match_ff   <= match_in;
   end

   assign s1_valid_in     = issue;
   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ff.ok;
   assign rsp_node_index  = rsp_ff.node_index;
   assign rsp_node_degree = rsp_ff.node_degree;
   assign rsp_node_total  = rsp_ff.node_total;

`ifndef SYNTH
   // The table never holds more nodes than it has room for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_NODES))
      else $error("node count beyond table size");

   // Neighbor degree writes only come out of an add in progress.
   a_dist_in_add: assert property (@(posedge clock) disable iff (reset)
      dist_out_valid |-> (state_ff == S_ADD_SCAN || state_ff == S_ADD_DRAIN))
      else $error("distance result outside an add");

   // The new node is stored only once the distance pipe has drained.
   a_fin_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ADD_FIN) |-> (!dist_busy && !s1_valid_ff))
      else $error("add finished with reads in flight");

   // An accepted item either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted item dropped");
`endif

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import pgdr_pkg::*;

   localparam int TABLE_DEPTH = MAX_NODES_DEFAULT;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic [DIST_BITS-1:0] DIST_ALL = {DIST_BITS{1'b1}};
   localparam int PHASE_ITEMS = 100;

   // One item waiting for the driver.
   typedef struct {
      logic [1:0]  command;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0]  rank;
      bit          hold;
   } req_item_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [1:0]              req_command = CMD_CLEAR;
   logic [15:0]             req_pos_x = '0;
   logic [15:0]             req_pos_y = '0;
   logic [7:0]              req_rank = '0;
   logic                    rsp_valid;
   logic                    rsp_ok;
   logic [7:0]              rsp_node_index;
   logic [7:0]              rsp_node_degree;
   logic [8:0]              rsp_node_total;
   logic                    csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = CSR_MIN_DIST;
   logic [DIST_BITS-1:0]    csr_write_data = '0;

   req_item_type item_backlog[$];
   rsp_type      pending_rsp[$];

   // Shadow copy of the node table and of the distance window.
   logic [15:0]          node_x[TABLE_DEPTH];
   logic [15:0]          node_y[TABLE_DEPTH];
   logic [7:0]           node_deg[TABLE_DEPTH];
   int                   node_count = 0;
   logic [DIST_BITS-1:0] win_lo = '0;
   logic [DIST_BITS-1:0] win_hi = DIST_BITS'(1);

   int fail_count = 0;
   int idle_pct = 0;
   int spread = 0;
   int phase_items = 0;
   bit item_taken = 1'b0;
   bit offering = 1'b0;

   proximity_graph_degree_ranker_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_rank         (req_rank),
      .rsp_valid        (rsp_valid),
      .rsp_ok           (rsp_ok),
      .rsp_node_index   (rsp_node_index),
      .rsp_node_degree  (rsp_node_degree),
      .rsp_node_total   (rsp_node_total),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // Apply one item to the shadow table and return the result it must produce.
   function automatic rsp_type rank_table_step(input logic [1:0] cmd, input logic [15:0] px,
                                               input logic [15:0] py, input logic [7:0] want);
      rsp_type         r;
      longint unsigned dx;
      longint unsigned dy;
      longint unsigned sq_sum;
      int              i;
      int              j;
      int              place;
      bit              found;
      r = '0;
      case (cmd)
         CMD_CLEAR: begin
            node_count = 0;
            r.ok = 1'b1;
         end
         CMD_ADD: begin
            if (node_count < TABLE_DEPTH) begin
               node_deg[node_count] = 8'd0;
               for (i = 0; i < node_count; i++) begin
                  dx = 64'((px > node_x[i]) ? px - node_x[i] : node_x[i] - px);
                  dy = 64'((py > node_y[i]) ? py - node_y[i] : node_y[i] - py);
                  sq_sum = dx * dx + dy * dy;
                  if (sq_sum > win_lo && sq_sum < win_hi) begin
                     // Degrees saturate at the top of their range.
                     if (node_deg[i] != 8'hFF) node_deg[i] = node_deg[i] + 8'd1;
                     if (node_deg[node_count] != 8'hFF)
                        node_deg[node_count] = node_deg[node_count] + 8'd1;
                  end
               end
               node_x[node_count] = px;
               node_y[node_count] = py;
               node_count++;
               r.ok = 1'b1;
            end
         end
         CMD_RANK: begin
            // Place of node i: nodes of higher degree, or equal degree and higher index.
            found = 1'b0;
            if (want < node_count) begin
               for (i = 0; i < node_count && !found; i++) begin
                  place = 0;
                  for (j = 0; j < node_count; j++) begin
                     if (node_deg[j] > node_deg[i] || (node_deg[j] == node_deg[i] && j > i))
                        place++;
                  end
                  if (place == want) begin
                     found = 1'b1;
                     r.ok = 1'b1;
                     r.node_index = i[7:0];
                     r.node_degree = node_deg[i];
                  end
               end
            end
         end
         default: begin
         end
      endcase
      r.node_total = node_count[8:0];
      return r;
   endfunction

   task automatic check_field(input string what, input logic [8:0] want, input logic [8:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // Driver: offers the oldest pending item, with random gaps between items.
   always @(negedge clock) begin
      logic go;
      if (item_taken) begin
         item_taken = 1'b0;
         offering = 1'b0;
      end
      go = offering;
      if (!offering && !reset && item_backlog.size() > 0) begin
         if ($urandom_range(0, 99) >= idle_pct &&
             !(item_backlog[0].hold && pending_rsp.size() > 0)) begin
            req_command <= item_backlog[0].command;
            req_pos_x <= item_backlog[0].pos_x;
            req_pos_y <= item_backlog[0].pos_y;
            req_rank <= item_backlog[0].rank;
            offering = 1'b1;
            go = 1'b1;
         end
      end
      start <= go;
   end

   // Monitor: predicts on each accepted item, then checks any result strobed this cycle.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (start && !busy) begin
            pending_rsp.insert(pending_rsp.size(),
                               rank_table_step(req_command, req_pos_x, req_pos_y, req_rank));
            item_backlog.delete(0);
            item_taken = 1'b1;
         end
         if (rsp_valid) begin
            if (pending_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: result with no item outstanding, actual ok %0d index %0d",
                        $time, rsp_ok, rsp_node_index);
            end else begin
               want = pending_rsp.pop_front();
               check_field("ok", 9'(want.ok), 9'(rsp_ok));
               check_field("node_index", 9'(want.node_index), 9'(rsp_node_index));
               check_field("node_degree", 9'(want.node_degree), 9'(rsp_node_degree));
               check_field("node_total", want.node_total, rsp_node_total);
            end
         end
      end
   end

   task automatic queue_item(input logic [1:0] cmd, input logic [15:0] px,
                             input logic [15:0] py, input logic [7:0] rk, input bit hold);
      req_item_type it;
      it.command = cmd;
      it.pos_x = px;
      it.pos_y = py;
      it.rank = rk;
      it.hold = hold;
      item_backlog.insert(item_backlog.size(), it);
      phase_items++;
   endtask

   // Wait until every item is taken and answered, then let the block settle.
   task automatic wait_idle();
      while (item_backlog.size() != 0 || pending_rsp.size() != 0) @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Both thresholds are written while the block is idle.
   task automatic write_window(input logic [DIST_BITS-1:0] lo, input logic [DIST_BITS-1:0] hi);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_MIN_DIST;
      csr_write_data <= lo;
      @(negedge clock);
      csr_index <= CSR_MAX_DIST;
      csr_write_data <= hi;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      win_lo = lo;
      win_hi = hi;
   endtask

   // Coordinate near a cluster base, or anywhere now and then.
   function automatic logic [15:0] near_coord(input logic [15:0] base);
      logic [15:0] off;
      off = 16'($urandom_range(0, spread));
      return ($urandom_range(0, 4) == 0) ? 16'($urandom) : base + off;
   endfunction

   // A cleared table built up by adds mixed with rank reads, or a burst of noise.
   task automatic add_sequence(input bit force_full);
      int          n_steps;
      int          k;
      int          live;
      logic [15:0] bx;
      logic [15:0] by;
      logic [7:0]  rk;
      if (!force_full && $urandom_range(0, 99) < 15) begin
         n_steps = $urandom_range(1, 6);
         for (k = 0; k < n_steps; k++)
            queue_item(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                       8'($urandom), 1'b0);
      end else begin
         bx = 16'($urandom);
         by = 16'($urandom);
         live = 0;
         queue_item(CMD_CLEAR, 16'($urandom), 16'($urandom), 8'($urandom), 1'b0);
         // When forced, or now and then, the table is filled past its capacity.
         if (force_full || $urandom_range(0, 59) == 0) begin
            for (k = 0; k < TABLE_DEPTH + 2; k++)
               queue_item(CMD_ADD, near_coord(bx), near_coord(by), 8'($urandom), 1'b0);
            live = TABLE_DEPTH;
         end
         n_steps = $urandom_range(2, 24);
         for (k = 0; k < n_steps; k++) begin
            if ($urandom_range(0, 99) < 60) begin
               queue_item(CMD_ADD, near_coord(bx), near_coord(by), 8'($urandom), 1'b0);
               if (live < TABLE_DEPTH) live++;
            end else begin
               rk = (live > 0 && $urandom_range(0, 4) != 0) ? 8'($urandom_range(0, live - 1))
                                                            : 8'($urandom);
               queue_item(CMD_RANK, 16'($urandom), 16'($urandom), rk,
                          $urandom_range(0, 29) == 0);
            end
         end
      end
   endtask

   task automatic run_phase(input int pct, input int spr, input bit derive,
                            input logic [DIST_BITS-1:0] lo, input logic [DIST_BITS-1:0] hi,
                            input bit force_full);
      logic [DIST_BITS-1:0] wlo;
      logic [DIST_BITS-1:0] whi;
      int unsigned          s2;
      s2 = spr * spr;
      wlo = lo;
      whi = hi;
      if (derive) begin
         wlo = DIST_BITS'($urandom_range(0, s2 / 2));
         whi = wlo + DIST_BITS'(1) + DIST_BITS'($urandom_range(0, 2 * s2));
      end
      write_window(wlo, whi);
      idle_pct = pct;
      spread = spr;
      phase_items = 0;
      if (force_full) add_sequence(1'b1);
      while (phase_items < PHASE_ITEMS) add_sequence(1'b0);
      wait_idle();
   endtask

   // Stimulus and end of run.
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // With the reset window no pair can be neighbors.
      queue_item(CMD_RANK, 16'h0000, 16'h0000, 8'd0, 1'b0);
      queue_item(CMD_CLEAR, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
      queue_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
      queue_item(CMD_ADD, 16'h0000, 16'h0000, 8'd0, 1'b0);
      queue_item(CMD_ADD, 16'hFFFF, 16'hFFFF, 8'd0, 1'b0);
      queue_item(CMD_RANK, 16'h0000, 16'h0000, 8'd0, 1'b0);
      queue_item(CMD_RANK, 16'h0000, 16'h0000, 8'd1, 1'b0);
      queue_item(CMD_RANK, 16'h0000, 16'h0000, 8'd2, 1'b0);
      queue_item(CMD_RANK, 16'h0000, 16'h0000, 8'hFF, 1'b0);
      wait_idle();

      // Widest window: opposite corners count, identical positions do not.
      write_window('0, DIST_ALL);
      queue_item(CMD_CLEAR, 16'h0000, 16'h0000, 8'd0, 1'b0);
      queue_item(CMD_ADD, 16'h0000, 16'h0000, 8'd0, 1'b0);
      queue_item(CMD_ADD, 16'hFFFF, 16'hFFFF, 8'd0, 1'b0);
      queue_item(CMD_ADD, 16'h0000, 16'h0000, 8'd0, 1'b0);
      queue_item(CMD_ADD, 16'h0001, 16'h0000, 8'd0, 1'b0);
      queue_item(CMD_RANK, 16'h0000, 16'h0000, 8'd0, 1'b0);
      queue_item(CMD_RANK, 16'h0000, 16'h0000, 8'd1, 1'b0);
      queue_item(CMD_RANK, 16'h0000, 16'h0000, 8'd2, 1'b0);
      queue_item(CMD_RANK, 16'h0000, 16'h0000, 8'd3, 1'b1);
      queue_item(CMD_RANK, 16'h0000, 16'h0000, 8'd4, 1'b0);
      queue_item(CMD_UNUSED, 16'h0000, 16'h0000, 8'd0, 1'b0);
      queue_item(CMD_CLEAR, 16'h0000, 16'h0000, 8'd0, 1'b0);
      queue_item(CMD_RANK, 16'h0000, 16'h0000, 8'd0, 1'b0);
      wait_idle();

      // Random phases over several windows and sender gap rates.
      run_phase(0, 50, 1'b1, '0, '0, 1'b0);
      run_phase(65, 300, 1'b1, '0, '0, 1'b0);
      run_phase(6, 65535, 1'b0, '0, DIST_ALL, 1'b1);
      run_phase(65, 40, 1'b0, DIST_ALL, DIST_ALL, 1'b0);
      run_phase(0, 40, 1'b0, '0, '0, 1'b0);
      run_phase(6, 1000, 1'b1, '0, '0, 1'b1);
      run_phase(65, 8, 1'b1, '0, '0, 1'b0);

      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog for a block that stops answering.
   initial begin
      #100_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
